// File: rtl/core/mtq_pkg.sv
// Package for the multilevel priority task queue: sizes, status codes,
// and the command/decision structs shared between the scheduler and the top level.
// No dependencies.
package mtq_pkg;

   localparam int LEVELS      = 10;
   localparam int LEVEL_DEPTH = 32;
   localparam int TASK_BITS   = 16;

   localparam int STORE_DEPTH = LEVELS * LEVEL_DEPTH;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int LVL_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int SLOT_W      = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W       = $clog2(LEVEL_DEPTH + 1);
   localparam int TOTAL_W     = $clog2(STORE_DEPTH + 1);

   // Payload widths fixed by the channel definition
   localparam int ID_W   = 16;
   localparam int PRIO_W = 4;
   localparam int STAT_W = 2;
   localparam int LEFT_W = 9;

   localparam logic ACT_ENQ = 1'b0;
   localparam logic ACT_DEQ = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPR = 2'd3;

   typedef struct packed {
      logic              fire;    // beat accepted this cycle
      logic              action;
      logic [PRIO_W-1:0] level;
   } sched_cmd_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic               wr_en;    // enqueue stores the id
      logic               rd_en;    // dequeue reads the head entry
      logic [ADDR_W-1:0]  addr;
      logic [PRIO_W-1:0]  out_level;
      logic [TOTAL_W-1:0] total;    // count after this beat
   } sched_dec_type;

endpackage

// File: rtl/core/mtq_if.sv
// Valid/ready channel interfaces for the task queue request and response beats.
// Depends on mtq_pkg.
interface mtq_req_if;
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [mtq_pkg::ID_W-1:0]   task_id;
   logic [mtq_pkg::PRIO_W-1:0] level;

   modport source (output valid, action, task_id, level, input ready);
   modport sink   (input valid, action, task_id, level, output ready);
endinterface

interface mtq_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      got_task;
   logic [mtq_pkg::ID_W-1:0]   out_task_id;
   logic [mtq_pkg::PRIO_W-1:0] out_level;
   logic [mtq_pkg::STAT_W-1:0] status;
   logic [mtq_pkg::LEFT_W-1:0] tasks_left;

   modport source (output valid, got_task, out_task_id, out_level, status, tasks_left,
                   input ready);
   modport sink   (input valid, got_task, out_task_id, out_level, status, tasks_left,
                   output ready);
endinterface

// File: rtl/core/mtq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mtq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 320
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/mtq_sched.sv
// Per-level ring pointers and counts, priority pick and store address generation.
// Depends on mtq_pkg.
module mtq_sched (
   input  logic                   clock,
   input  logic                   reset,
   input  mtq_pkg::sched_cmd_type cmd,
   output mtq_pkg::sched_dec_type dec
);
   import mtq_pkg::*;

   logic [SLOT_W-1:0] head_ff  [LEVELS];
   logic [SLOT_W-1:0] tail_ff  [LEVELS];
   logic [CNT_W-1:0]  count_ff [LEVELS];
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic             bad_prio;
   logic [LVL_W-1:0] enq_q;
   logic             any_busy;
   logic [LVL_W-1:0] deq_q;
   logic [LVL_W-1:0] sel_q;
   logic [SLOT_W-1:0] sel_slot;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      if (s == SLOT_W'(LEVEL_DEPTH - 1)) begin
         return '0;
      end
      return s + SLOT_W'(1);
   endfunction

   // Lowest non-empty level wins
   always_comb begin
      any_busy = 1'b0;
      deq_q    = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (count_ff[i] != '0) begin
            any_busy = 1'b1;
            deq_q    = LVL_W'(i);
         end
      end
   end

   assign bad_prio = (cmd.level == '0) || (int'(cmd.level) > LEVELS);
   assign enq_q    = LVL_W'(cmd.level - PRIO_W'(1));
   assign sel_q    = (cmd.action == ACT_DEQ) ? deq_q : enq_q;
   assign sel_slot = (cmd.action == ACT_DEQ) ? head_ff[sel_q] : tail_ff[sel_q];

   always_comb begin
      dec           = '0;
      dec.addr      = ADDR_W'(ADDR_W'(sel_q) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(sel_slot));
      total_in      = total_ff;
      if (cmd.action == ACT_ENQ) begin
         if (bad_prio) begin
            dec.status = ST_BADPR;
         end else if (count_ff[enq_q] == CNT_W'(LEVEL_DEPTH)) begin
            dec.status = ST_FULL;
         end else begin
            dec.status = ST_OK;
            dec.wr_en  = cmd.fire;
            total_in   = total_ff + TOTAL_W'(1);
         end
      end else begin
         if (!any_busy) begin
            dec.status = ST_EMPTY;
         end else begin
            dec.status    = ST_OK;
            dec.rd_en     = cmd.fire;
            dec.out_level = PRIO_W'(deq_q) + PRIO_W'(1);
            total_in      = total_ff - TOTAL_W'(1);
         end
      end
      dec.total = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         for (int i = 0; i < LEVELS; i++) begin
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         if (dec.wr_en) begin
            tail_ff[enq_q]  <= next_slot(tail_ff[enq_q]);
            count_ff[enq_q] <= count_ff[enq_q] + CNT_W'(1);
            total_ff        <= total_in;
         end
         if (dec.rd_en) begin
            head_ff[deq_q]  <= next_slot(head_ff[deq_q]);
            count_ff[deq_q] <= count_ff[deq_q] - CNT_W'(1);
            total_ff        <= total_in;
         end
      end
   end

endmodule

// File: rtl/core/multilevel_priority_task_queue.sv
// Strict-priority task queue, ten FIFO levels over one shared task store RAM.
// Response: enqueue and rejected beats respond in the cycle after acceptance;
//   a successful dequeue responds after the registered RAM read of the head entry.
// Throughput: one enqueue per cycle while the response slot is free; no new beat
//   is accepted while a dequeue waits on the registered read port of the task store.
// Reset: synchronous, clears all pointers, counts, the state and the response valid flag.
module multilevel_priority_task_queue (
   input logic           clock,
   input logic           reset,
   mtq_req_if.sink       req_ch,
   mtq_rsp_if.source     rsp_ch
);
   import mtq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   state_type state_ff, state_in;

   sched_cmd_type cmd;
   sched_dec_type dec;

   logic                 fire;
   logic                 rsp_free;
   logic [TASK_BITS-1:0] rd_data;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 got_ff, got_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [PRIO_W-1:0]    lvl_ff, lvl_in;
   logic [STAT_W-1:0]    stat_ff, stat_in;
   logic [LEFT_W-1:0]    left_ff, left_in;

   // Held across the RAM read of a dequeue
   logic [PRIO_W-1:0]    pend_lvl_ff, pend_lvl_in;
   logic [LEFT_W-1:0]    pend_left_ff, pend_left_in;

   // Take a beat only in S_IDLE and when the response slot is empty or emptying this cycle
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) && rsp_free;
   assign fire         = req_ch.valid && req_ch.ready;

   assign cmd.fire   = fire;
   assign cmd.action = req_ch.action;
   assign cmd.level  = req_ch.level;

   mtq_sched u_sched (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .dec   (dec)
   );

   mtq_ram #(
      .WIDTH (TASK_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (dec.wr_en),
      .wr_addr (dec.addr),
      .wr_data (TASK_BITS'(req_ch.task_id)),
      .rd_en   (dec.rd_en),
      .rd_addr (dec.addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      got_in       = got_ff;
      id_in        = id_ff;
      lvl_in       = lvl_ff;
      stat_in      = stat_ff;
      left_in      = left_ff;
      pend_lvl_in  = pend_lvl_ff;
      pend_left_in = pend_left_ff;
      case (state_ff)
         S_IDLE: begin
            if (fire) begin
               if (dec.rd_en) begin
                  // hit: wait for the registered read of the head entry
                  pend_lvl_in  = dec.out_level;
                  pend_left_in = LEFT_W'(dec.total);
                  state_in     = S_READ;
               end else begin
                  rsp_valid_in = 1'b1;
                  got_in       = 1'b0;
                  id_in        = '0;
                  lvl_in       = '0;
                  stat_in      = dec.status;
                  left_in      = LEFT_W'(dec.total);
               end
            end
         end
         S_READ: begin
            // slot was freed at acceptance, so it is empty now
            rsp_valid_in = 1'b1;
            got_in       = 1'b1;
            id_in        = ID_W'(rd_data);
            lvl_in       = pend_lvl_ff;
            stat_in      = ST_OK;
            left_in      = pend_left_ff;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      got_ff       <= got_in;
      id_ff        <= id_in;
      lvl_ff       <= lvl_in;
      stat_ff      <= stat_in;
      left_ff      <= left_in;
      pend_lvl_ff  <= pend_lvl_in;
      pend_left_ff <= pend_left_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.got_task    = got_ff;
   assign rsp_ch.out_task_id = id_ff;
   assign rsp_ch.out_level   = lvl_ff;
   assign rsp_ch.status      = stat_ff;
   assign rsp_ch.tasks_left  = left_ff;

endmodule
